### hdl/voxel_air_element_selector_top_macros.svh
// assertion macros shared by the voxel air element selector modules
`ifndef VOXEL_AIR_ELEMENT_SELECTOR_TOP_MACROS_SVH
`define VOXEL_AIR_ELEMENT_SELECTOR_TOP_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define VAES_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vaes assertion failed");
// consequent must hold in the cycle after the antecedent
`define VAES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vaes assertion failed");
`else
`define VAES_ASSERT(label, clk, rst_n, prop)
`define VAES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/vaes_pkg.sv
// types, constants and helper functions of the voxel air element selector
`timescale 1ns / 1ps
package vaes_pkg;

    localparam int unsigned NUM_CORNERS = 8;
    localparam int unsigned NUM_BASIS   = 27;
    localparam int unsigned PT_W        = 24;
    localparam int unsigned STRIDE_W    = 24;
    localparam int unsigned OFF_W       = STRIDE_W + 1;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] AIR_CODE = 8'h61;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_STRIDE_Y = 1'b0,
        CFG_STRIDE_Z = 1'b1
    } t_cfg_index;

    // one classified item, as held in the queue
    typedef struct packed {
        logic [PT_W-1:0] point;
        logic [7:0]      air_mask;
        logic [4:0]      basis_count;
        logic [3:0]      air_count;
    } t_entry;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // 2x2x2 subcube of each corner within the 3x3x3 basis set
    function automatic logic [NUM_BASIS-1:0] corner_basis(input logic [2:0] k);
        logic [NUM_BASIS-1:0] m;
        unique case (k)
            3'd0: m = 27'h6C36000;
            3'd1: m = 27'h361B000;
            3'd2: m = 27'h0D86C00;
            3'd3: m = 27'h06C3600;
            3'd4: m = 27'h00361B0;
            3'd5: m = 27'h001B0D8;
            3'd6: m = 27'h0006C36;
            3'd7: m = 27'h000361B;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] popcount27(input logic [NUM_BASIS-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < NUM_BASIS; i++) begin
            n = n + 5'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

### hdl/voxel_air_element_selector_top.sv
// top level of the voxel air element selector
`timescale 1ns / 1ps
// takes one grid point per item (linear index and the material bytes of its eight
// diagonal neighbours) and sends one result per air corner in corner order 0..7,
// or a single result with elem_valid low when no corner is air; is_last marks the
// final result of each item. the back end sends one result per clock while not
// stalled, so an item with n air corners gives max(n,1) results, eight at most; an
// accepted item passes the queue, then the output register. the front end classifies
// items (air mask, basis union popcount, air count) in the accept cycle and drops them
// into a two-entry queue, so input and output stall independently and input flows
// while a result waits there until the queue fills. the user must write strides through
// the config port only while idle (not enforced); index 0 is stride_y, 1 is stride_z
module voxel_air_element_selector_top import vaes_pkg::*; #(
    parameter int unsigned INDEX_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config write port
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [STRIDE_W-1:0] i_cfg_data,
    // input item channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [PT_W-1:0]     i_point_index,
    input  logic [7:0]          i_mat_c0,
    input  logic [7:0]          i_mat_c1,
    input  logic [7:0]          i_mat_c2,
    input  logic [7:0]          i_mat_c3,
    input  logic [7:0]          i_mat_c4,
    input  logic [7:0]          i_mat_c5,
    input  logic [7:0]          i_mat_c6,
    input  logic [7:0]          i_mat_c7,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_elem_valid,
    output logic [2:0]          o_corner_code,
    output logic [PT_W-1:0]     o_elem_index,
    output logic                o_out_of_grid,
    output logic [4:0]          o_basis_count,
    output logic [3:0]          o_air_count,
    output logic                o_is_last
);

    logic [7:0] mat [NUM_CORNERS];
    t_entry     push_entry;
    t_entry     head;
    t_q_stat    q_stat;
    logic       push;
    logic       pop;
    t_cfg_index cfg_index;

    // corner order: +z+y+1, +z+y-1, +z-y+1, +z-y-1, -z+y+1, -z+y-1, -z-y+1, -z-y-1
    assign mat[0] = i_mat_c0;
    assign mat[1] = i_mat_c1;
    assign mat[2] = i_mat_c2;
    assign mat[3] = i_mat_c3;
    assign mat[4] = i_mat_c4;
    assign mat[5] = i_mat_c5;
    assign mat[6] = i_mat_c6;
    assign mat[7] = i_mat_c7;

    assign cfg_index = t_cfg_index'(i_cfg_index);

    // classify and accept
    vaes_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_point_index (i_point_index),
        .i_mat         (mat),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // decoupling queue
    vaes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // per-corner result generation
    vaes_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_elem_valid  (o_elem_valid),
        .o_corner_code (o_corner_code),
        .o_elem_index  (o_elem_index),
        .o_out_of_grid (o_out_of_grid),
        .o_basis_count (o_basis_count),
        .o_air_count   (o_air_count),
        .o_is_last     (o_is_last)
    );

endmodule

### hdl/vaes_front.sv
// front end: input handshake, air detection, basis union and counts
`timescale 1ns / 1ps
module vaes_front import vaes_pkg::*; #(
    parameter int unsigned INDEX_BITS = 24
) (
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [PT_W-1:0] i_point_index,
    input  logic [7:0]      i_mat [NUM_CORNERS],
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output t_entry          o_entry
);

    localparam int unsigned PT_BITS = (INDEX_BITS < PT_W) ? INDEX_BITS : PT_W;
    localparam logic [PT_W-1:0] PT_MASK = PT_W'((64'd1 << PT_BITS) - 64'd1);

    logic [7:0]           air_mask;
    logic [NUM_BASIS-1:0] uni;

    always_comb begin
        uni = '0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            air_mask[k] = (i_mat[k] == AIR_CODE);
            if (air_mask[k]) begin
                uni = uni | corner_basis(3'(k));
            end
        end
    end

    assign o_in_stall           = i_q_stat.full;
    assign o_push               = i_in_valid && !i_q_stat.full;
    assign o_entry.point        = i_point_index & PT_MASK;
    assign o_entry.air_mask     = air_mask;
    assign o_entry.basis_count  = popcount27(uni);
    assign o_entry.air_count    = popcount8(air_mask);

endmodule

### hdl/vaes_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module vaes_queue import vaes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);

endmodule

### hdl/vaes_back.sv
// back end: stride registers, per-corner index arithmetic, result register
`timescale 1ns / 1ps
`include "voxel_air_element_selector_top_macros.svh"
module vaes_back import vaes_pkg::*; #(
    parameter int unsigned INDEX_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_index          i_cfg_index,
    input  logic [STRIDE_W-1:0] i_cfg_data,
    input  t_entry              i_head,
    input  t_q_stat             i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_elem_valid,
    output logic [2:0]          o_corner_code,
    output logic [PT_W-1:0]     o_elem_index,
    output logic                o_out_of_grid,
    output logic [4:0]          o_basis_count,
    output logic [3:0]          o_air_count,
    output logic                o_is_last
);

    localparam int unsigned PT_BITS = (INDEX_BITS < PT_W) ? INDEX_BITS : PT_W;
    localparam logic [PT_W-1:0] PT_MASK = PT_W'((64'd1 << PT_BITS) - 64'd1);

    logic [STRIDE_W-1:0] r_stride_y;
    logic [STRIDE_W-1:0] r_stride_z;
    logic [OFF_W-1:0]    r_stride_yz;
    logic [7:0]          r_done, n_done;

    logic                r_out_valid;
    logic                r_elem_valid;
    logic [2:0]          r_corner_code;
    logic [PT_W-1:0]     r_elem_index;
    logic                r_out_of_grid;
    logic [4:0]          r_basis_count;
    logic [3:0]          r_air_count;
    logic                r_is_last;

    logic                load_ok;
    logic                fire;
    logic                any_air;
    logic [7:0]          pending;
    logic [7:0]          pick;
    logic [2:0]          corner;
    logic                last;
    logic [OFF_W-1:0]    base;
    logic [OFF_W:0]      diff;

    // stride registers, y+z kept ready for the diagonal corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride_y  <= STRIDE_W'(1);
            r_stride_z  <= STRIDE_W'(1);
            r_stride_yz <= OFF_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRIDE_Y: begin
                    r_stride_y  <= i_cfg_data;
                    r_stride_yz <= {1'b0, i_cfg_data} + {1'b0, r_stride_z};
                end
                CFG_STRIDE_Z: begin
                    r_stride_z  <= i_cfg_data;
                    r_stride_yz <= {1'b0, r_stride_y} + {1'b0, i_cfg_data};
                end
                default: ;
            endcase
        end
    end

    // lowest corner still to send for the head item
    always_comb begin
        pending = i_head.air_mask & ~r_done;
        pick    = pending & (~pending + 8'd1);
        corner  = '0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            if (pick[k]) begin
                corner = 3'(k);
            end
        end
        last    = ((pending & ~pick) == '0);
        any_air = (i_head.air_mask != '0);
        unique case (corner[2:1])
            2'd0: base = '0;
            2'd1: base = {1'b0, r_stride_y};
            2'd2: base = {1'b0, r_stride_z};
            2'd3: base = r_stride_yz;
            default: base = '0;
        endcase
        // point - base - corner[0]: top bit is the borrow
        diff = {2'b00, i_head.point} - {1'b0, base} - (OFF_W + 1)'(corner[0]);
    end

    assign load_ok = !r_out_valid || !i_out_stall;
    assign fire    = i_q_stat.not_empty && load_ok;
    assign o_pop   = fire && last;

    always_comb begin
        n_done = r_done;
        if (fire) begin
            n_done = last ? '0 : (r_done | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load_ok) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_elem_valid  <= any_air;
            r_corner_code <= any_air ? corner : '0;
            r_elem_index  <= any_air ? (diff[PT_W-1:0] & PT_MASK) : '0;
            r_out_of_grid <= any_air && diff[OFF_W];
            r_basis_count <= i_head.basis_count;
            r_air_count   <= i_head.air_count;
            r_is_last     <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_elem_valid  = r_elem_valid;
    assign o_corner_code = r_corner_code;
    assign o_elem_index  = r_elem_index;
    assign o_out_of_grid = r_out_of_grid;
    assign o_basis_count = r_basis_count;
    assign o_air_count   = r_air_count;
    assign o_is_last     = r_is_last;

    `VAES_ASSERT(a_empty_is_last, i_clk, i_rst_n, r_out_valid && !r_elem_valid |-> r_is_last && r_air_count == 4'd0)
    `VAES_ASSERT(a_air_counts, i_clk, i_rst_n, r_out_valid && r_elem_valid |-> r_basis_count >= 5'd8 && r_air_count != 4'd0)
    `VAES_ASSERT(a_done_idle, i_clk, i_rst_n, !i_q_stat.not_empty |-> r_done == 8'd0)
    `VAES_ASSERT(a_done_subset, i_clk, i_rst_n, (r_done & ~i_head.air_mask) == 8'd0 || !i_q_stat.not_empty)
    `VAES_ASSERT_NEXT(a_pop_clears, i_clk, i_rst_n, o_pop, r_done == 8'd0)

endmodule
